// File: rtl/desync_episode_leaky_bucket_defines.svh
// Assertion macros for the desync episode leaky bucket.
// Included by the top level; no other dependencies.
`ifndef DESYNC_EPISODE_LEAKY_BUCKET_DEFINES_SVH
`define DESYNC_EPISODE_LEAKY_BUCKET_DEFINES_SVH

// same-cycle implication
`define DELB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DELB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/delb_pkg.sv
// Shared types and constants for the desync episode leaky bucket.
// No dependencies.
package delb_pkg;

  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EPISODE_LIMIT = 3'd0,
    CFG_CHARGE_JUMP   = 3'd1,
    CFG_CHARGE_STALL  = 3'd2,
    CFG_DRAIN_PERIOD  = 3'd3,
    CFG_BACKOFF_MIN   = 3'd4,
    CFG_BACKOFF_BASE  = 3'd5,
    CFG_BACKOFF_STEP  = 3'd6,
    CFG_BACKOFF_MAX   = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_STALL = 3'd1,
    OP_JUMP  = 3'd2,
    OP_EARLY = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  localparam logic [7:0]  EARLY_DESYNC_LIMIT  = 8'd20;
  localparam logic [15:0] ACQ_CLEAR_CROSSINGS = 16'd500;
  localparam logic [7:0]  SAT8                = 8'hFF;

  localparam logic [7:0] RST_EPISODE_LIMIT = 8'd40;
  localparam logic [7:0] RST_CHARGE_JUMP   = 8'd8;
  localparam logic [7:0] RST_CHARGE_STALL  = 8'd12;
  localparam logic [7:0] RST_DRAIN_PERIOD  = 8'd100;
  localparam logic [7:0] RST_BACKOFF_MIN   = 8'd16;
  localparam logic [9:0] RST_BACKOFF_BASE  = 10'd100;
  localparam logic [7:0] RST_BACKOFF_STEP  = 8'd25;
  localparam logic [9:0] RST_BACKOFF_MAX   = 10'd500;

  typedef struct packed {
    logic [7:0] episode_limit;
    logic [7:0] charge_jump;
    logic [7:0] charge_stall;
    logic [7:0] drain_period_ms;
    logic [7:0] backoff_min_level;
    logic [9:0] backoff_base_ms;
    logic [7:0] backoff_step_ms;
    logic [9:0] backoff_max_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] zero_cross_count;
    logic        closed_loop;
    logic        blind_idle;
    logic        demag_idle;
  } item_t;

  typedef struct packed {
    logic [7:0] bucket;
    logic [7:0] drain_counter;
    logic [9:0] holdoff_counter;
    logic [7:0] early_count;
    logic [7:0] resist_count;
  } state_t;

  typedef struct packed {
    logic [7:0] bucket_level;
    logic [9:0] holdoff_left;
    logic       holdoff_active;
    logic       fault_trip;
    logic [7:0] resist_events;
    logic [7:0] early_desync_count;
  } result_t;

endpackage

// File: rtl/delb_evt_if.sv
// Event channel: valid/ready handshake with one event item as payload.
// No dependencies.
interface delb_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] zero_cross_count;
  logic        closed_loop;
  logic        blind_idle;
  logic        demag_idle;

  modport source (output valid, opcode, zero_cross_count, closed_loop, blind_idle,
                  demag_idle, input ready);
  modport sink (input valid, opcode, zero_cross_count, closed_loop, blind_idle,
                demag_idle, output ready);
endinterface

// File: rtl/delb_res_if.sv
// Result channel: valid/ready handshake with one status item as payload.
// No dependencies.
interface delb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] bucket_level;
  logic [9:0] holdoff_left;
  logic       holdoff_active;
  logic       fault_trip;
  logic [7:0] resist_events;
  logic [7:0] early_desync_count;

  modport source (output valid, bucket_level, holdoff_left, holdoff_active, fault_trip,
                  resist_events, early_desync_count, input ready);
  modport sink (input valid, bucket_level, holdoff_left, holdoff_active, fault_trip,
                resist_events, early_desync_count, output ready);
endinterface

// File: rtl/desync_episode_leaky_bucket.sv
// Desync episode leaky bucket: escalates motor desync episodes into a
// restart holdoff and a trip flag. One event item is taken per clock
// unless the result sink stalls; each produces one status item through
// the input register, then the result register. Sustained rate is one
// item per cycle, limited only by the result sink's ready; the state
// update for an item is a single registered pass through the
// charge/holdoff datapath (one 8x8 multiply plus add and clamp).
// Depends on delb_pkg, delb_evt_if, delb_res_if, delb_cfg_regs, delb_core
// and desync_episode_leaky_bucket_defines.svh.
`include "desync_episode_leaky_bucket_defines.svh"

module desync_episode_leaky_bucket (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [delb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [delb_pkg::CFG_DATA_W-1:0] cfg_data,
  delb_evt_if.sink                        evt,
  delb_res_if.source                      res
);
  import delb_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_advance;
  state_t  state;
  state_t  state_next;
  result_t core_result;
  result_t out_res;
  logic    out_valid;
  logic    charged;

  delb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  delb_core u_core (
    .cfg        (cfg),
    .item       (s1_item),
    .state      (state),
    .state_next (state_next),
    .result     (core_result),
    .charged    (charged)
  );

  assign s1_advance = s1_valid && (!out_valid || res.ready);
  assign evt.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (evt.ready) begin
      s1_valid <= evt.valid;
    end
    if (evt.ready && evt.valid) begin
      s1_item.opcode           <= evt.opcode;
      s1_item.zero_cross_count <= evt.zero_cross_count;
      s1_item.closed_loop      <= evt.closed_loop;
      s1_item.blind_idle       <= evt.blind_idle;
      s1_item.demag_idle       <= evt.demag_idle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s1_advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance)
      out_res <= core_result;
  end

  assign res.valid              = out_valid;
  assign res.bucket_level       = out_res.bucket_level;
  assign res.holdoff_left       = out_res.holdoff_left;
  assign res.holdoff_active     = out_res.holdoff_active;
  assign res.fault_trip         = out_res.fault_trip;
  assign res.resist_events      = out_res.resist_events;
  assign res.early_desync_count = out_res.early_desync_count;

  `DELB_ASSERT_NEXT(a_adv_gives_result, clk, rst, s1_advance, out_valid, "item processed without result")
  `DELB_ASSERT_NEXT(a_state_hold, clk, rst, !s1_advance, $stable(state), "state moved without an item")
  `DELB_ASSERT_NOW(a_stall_backpressure, clk, rst, s1_valid && out_valid && !res.ready, !evt.ready, "input taken while pipeline is full")
  `DELB_ASSERT_NEXT(a_holdoff_ceiling, clk, rst, s1_advance && charged, (state.holdoff_counter <= $past(cfg.backoff_max_ms)) || (state.holdoff_counter == $past(state.holdoff_counter)), "charge armed holdoff above ceiling")

endmodule

// File: rtl/delb_cfg_regs.sv
// Configuration register bank for the leaky bucket.
// Depends on delb_pkg.
module delb_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [delb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [delb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output delb_pkg::cfg_t                      cfg
);
  import delb_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.episode_limit     <= RST_EPISODE_LIMIT;
      cfg.charge_jump       <= RST_CHARGE_JUMP;
      cfg.charge_stall      <= RST_CHARGE_STALL;
      cfg.drain_period_ms   <= RST_DRAIN_PERIOD;
      cfg.backoff_min_level <= RST_BACKOFF_MIN;
      cfg.backoff_base_ms   <= RST_BACKOFF_BASE;
      cfg.backoff_step_ms   <= RST_BACKOFF_STEP;
      cfg.backoff_max_ms    <= RST_BACKOFF_MAX;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_EPISODE_LIMIT: cfg.episode_limit     <= cfg_data[7:0];
        CFG_CHARGE_JUMP:   cfg.charge_jump       <= cfg_data[7:0];
        CFG_CHARGE_STALL:  cfg.charge_stall      <= cfg_data[7:0];
        CFG_DRAIN_PERIOD:  cfg.drain_period_ms   <= cfg_data[7:0];
        CFG_BACKOFF_MIN:   cfg.backoff_min_level <= cfg_data[7:0];
        CFG_BACKOFF_BASE:  cfg.backoff_base_ms   <= cfg_data;
        CFG_BACKOFF_STEP:  cfg.backoff_step_ms   <= cfg_data[7:0];
        CFG_BACKOFF_MAX:   cfg.backoff_max_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/delb_core.sv
// Next-state and result logic for one event item.
// Depends on delb_pkg.
module delb_core (
  input  delb_pkg::cfg_t    cfg,
  input  delb_pkg::item_t   item,
  input  delb_pkg::state_t  state,
  output delb_pkg::state_t  state_next,
  output delb_pkg::result_t result,
  output logic              charged
);
  import delb_pkg::*;

  logic [7:0]  weight;
  logic [8:0]  bucket_sum;
  logic [7:0]  charged_bucket;
  logic [7:0]  level_over;
  logic [15:0] step_prod;
  logic [16:0] hold_raw;
  logic [9:0]  hold_clamped;
  logic [9:0]  armed_holdoff;
  logic [7:0]  early_inc;
  logic [7:0]  drain_inc;
  logic        healthy;
  logic        early_fire;
  logic        trip;

  always_comb begin
    early_inc  = state.early_count + 8'd1;
    early_fire = (early_inc >= EARLY_DESYNC_LIMIT);

    weight         = (item.opcode == OP_STALL) ? cfg.charge_stall : cfg.charge_jump;
    bucket_sum     = {1'b0, state.bucket} + {1'b0, weight};
    charged_bucket = bucket_sum[8] ? SAT8 : bucket_sum[7:0];

    // holdoff = base + (level - min) * step, clamped, never shortened
    level_over   = charged_bucket - cfg.backoff_min_level;
    step_prod    = {8'd0, level_over} * {8'd0, cfg.backoff_step_ms};
    hold_raw     = {7'd0, cfg.backoff_base_ms} + {1'b0, step_prod};
    hold_clamped = (hold_raw > {7'd0, cfg.backoff_max_ms}) ? cfg.backoff_max_ms
                                                           : hold_raw[9:0];
    if (charged_bucket >= cfg.backoff_min_level && hold_clamped > state.holdoff_counter)
      armed_holdoff = hold_clamped;
    else
      armed_holdoff = state.holdoff_counter;

    healthy   = item.closed_loop & item.blind_idle & item.demag_idle;
    drain_inc = (state.drain_counter == SAT8) ? state.drain_counter
                                              : state.drain_counter + 8'd1;

    state_next = state;
    charged    = 1'b0;

    case (op_t'(item.opcode))
      OP_TICK: begin
        if (item.zero_cross_count > ACQ_CLEAR_CROSSINGS)
          state_next.early_count = '0;
        if (state.holdoff_counter != '0)
          state_next.holdoff_counter = state.holdoff_counter - 10'd1;
        if (healthy && state.bucket != '0) begin
          if (drain_inc >= cfg.drain_period_ms) begin
            state_next.drain_counter = '0;
            state_next.bucket        = state.bucket - 8'd1;
          end else begin
            state_next.drain_counter = drain_inc;
          end
        end else begin
          state_next.drain_counter = '0;
        end
      end
      OP_STALL, OP_JUMP: begin
        charged = 1'b1;
      end
      OP_EARLY: begin
        if (early_fire) begin
          charged                = 1'b1;
          state_next.early_count = '0;
          if (state.resist_count != SAT8)
            state_next.resist_count = state.resist_count + 8'd1;
        end else begin
          state_next.early_count = early_inc;
        end
      end
      OP_CLEAR: begin
        state_next.bucket          = '0;
        state_next.holdoff_counter = '0;
        state_next.early_count     = '0;
      end
      default: ;
    endcase

    if (charged) begin
      state_next.bucket          = charged_bucket;
      state_next.drain_counter   = '0;
      state_next.holdoff_counter = armed_holdoff;
    end
    trip = charged && (charged_bucket >= cfg.episode_limit);

    result.bucket_level       = state_next.bucket;
    result.holdoff_left       = state_next.holdoff_counter;
    result.holdoff_active     = (state_next.holdoff_counter != '0);
    result.fault_trip         = trip;
    result.resist_events      = state_next.resist_count;
    result.early_desync_count = state_next.early_count;
  end

endmodule
